// ===== rtl/core/oqpt_pkg.sv =====
// Shared types, codes and widths of the order queue position tracker.
`timescale 1ns / 1ps

package oqpt_pkg;

  localparam int VOLUME_BITS = 32;
  localparam int SUM_BITS    = 48;
  localparam int DIV_BITS    = VOLUME_BITS + 1;
  localparam int TRY_BITS    = VOLUME_BITS + 3;
  localparam int STEP_BITS   = $clog2(VOLUME_BITS);
  localparam int CFG_IDX_BITS = 1;

  localparam logic [2:0] OP_START  = 3'd0;
  localparam logic [2:0] OP_TRADE  = 3'd1;
  localparam logic [2:0] OP_CANCEL = 3'd2;
  localparam logic [2:0] OP_ADD    = 3'd3;
  localparam logic [2:0] OP_CLEAR  = 3'd4;

  localparam logic [CFG_IDX_BITS-1:0] CFG_ORDER_SIZE = 1'b0;
  localparam logic [CFG_IDX_BITS-1:0] CFG_INIT_AHEAD = 1'b1;

  typedef struct packed {
    logic [2:0]             opcode;
    logic [VOLUME_BITS-1:0] volume;
  } in_t;

  typedef struct packed {
    logic [VOLUME_BITS-1:0] spillover_volume;
    logic [VOLUME_BITS-1:0] queue_ahead;
    logic [VOLUME_BITS-1:0] queue_behind;
    logic [VOLUME_BITS-1:0] executed_volume;
    logic [VOLUME_BITS-1:0] unfilled_volume;
    logic                   fully_executed;
    logic [SUM_BITS-1:0]    traded_total;
  } out_t;

  typedef struct packed {
    logic load;
    logic div_init;
    logic div_step;
    logic commit;
  } cmd_t;

  typedef struct packed {
    logic need_div;
  } status_t;

endpackage

// ===== rtl/core/oqpt_ctrl.sv =====
// Controller state machine: item intake, divider sequencing and result hand-off.
`timescale 1ns / 1ps

module oqpt_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  output logic              out_valid,
  input  logic              out_ready,
  input  oqpt_pkg::status_t status,
  output oqpt_pkg::cmd_t    cmd
);

  typedef enum logic [1:0] {
    S_IDLE,
    S_PREP,
    S_DIV,
    S_FIN
  } state_t;

  state_t                          state_r;
  logic [oqpt_pkg::STEP_BITS-1:0]  cnt_r;
  logic                            out_valid_r;
  logic                            commit_ok;

  assign in_ready     = (state_r == S_IDLE);
  assign out_valid    = out_valid_r;
  assign commit_ok    = (state_r == S_FIN) && (!out_valid_r || out_ready);

  assign cmd.load     = in_valid && (state_r == S_IDLE);
  assign cmd.div_init = (state_r == S_PREP);
  assign cmd.div_step = (state_r == S_DIV);
  assign cmd.commit   = commit_ok;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (commit_ok) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
      case (state_r)
        S_IDLE: begin
          if (in_valid) begin
            state_r <= S_PREP;
          end
        end
        S_PREP: begin
          cnt_r <= oqpt_pkg::STEP_BITS'(oqpt_pkg::VOLUME_BITS - 1);
          if (status.need_div) begin
            state_r <= S_DIV;
          end else begin
            state_r <= S_FIN;
          end
        end
        S_DIV: begin
          if (cnt_r == '0) begin
            state_r <= S_FIN;
          end else begin
            cnt_r <= cnt_r - 1'b1;
          end
        end
        S_FIN: begin
          if (commit_ok) begin
            state_r <= S_IDLE;
          end
        end
        default: begin
          state_r <= S_IDLE;
        end
      endcase
    end
  end

endmodule

// ===== rtl/core/oqpt_dp.sv =====
// Datapath: configuration, queue counters, bit-serial cancel divider, result register.
`timescale 1ns / 1ps

module oqpt_dp (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 cfg_we,
  input  logic [oqpt_pkg::CFG_IDX_BITS-1:0]    cfg_index,
  input  logic [oqpt_pkg::VOLUME_BITS-1:0]     cfg_wdata,
  input  oqpt_pkg::in_t                        in_data,
  input  oqpt_pkg::cmd_t                       cmd,
  output oqpt_pkg::status_t                    status,
  output oqpt_pkg::out_t                       out_data
);

  localparam int VW = oqpt_pkg::VOLUME_BITS;
  localparam int SW = oqpt_pkg::SUM_BITS;
  localparam int DW = oqpt_pkg::DIV_BITS;
  localparam int TW = oqpt_pkg::TRY_BITS;

  logic [VW-1:0]    order_size_r, init_ahead_r;
  logic [VW-1:0]    ahead_r, behind_r, filled_r;
  logic [VW-1:0]    ahead_nxt, behind_nxt, filled_nxt, spill_nxt;
  logic [SW-1:0]    sum_r, sum_nxt;
  oqpt_pkg::in_t    item_r;
  oqpt_pkg::out_t   out_r;

  logic [VW-1:0]    a_r, q_r;
  logic [DW-1:0]    rem_r, d_r;
  logic [TW-1:0]    try_v, d1_v, d2_v;
  logic [VW-1:0]    q_nxt;
  logic [DW-1:0]    rem_nxt;
  logic [DW:0]      q_dbl;

  logic [VW-1:0]    vol, left_now, left_nxt, past, cb;
  logic [SW:0]      sum_ext;
  logic [VW:0]      add_ext;
  logic [DW-1:0]    ca;
  logic signed [VW+1:0] na, nb;

  assign status.need_div = (item_r.opcode == oqpt_pkg::OP_CANCEL) && (behind_r != '0);
  assign out_data = out_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      order_size_r <= VW'(1);
      init_ahead_r <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        oqpt_pkg::CFG_ORDER_SIZE: order_size_r <= cfg_wdata;
        oqpt_pkg::CFG_INIT_AHEAD: init_ahead_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // restoring step of floor(volume * ahead / (ahead + behind))
  always_comb begin
    d1_v    = {2'b00, d_r};
    d2_v    = {1'b0, d_r, 1'b0};
    try_v   = {1'b0, rem_r, 1'b0} + (a_r[VW-1] ? {3'b000, ahead_r} : '0);
    q_dbl   = {1'b0, q_r, 1'b0};
    if (try_v >= d2_v) begin
      rem_nxt = DW'(try_v - d2_v);
      q_nxt   = VW'(q_dbl + (DW+1)'(2));
    end else if (try_v >= d1_v) begin
      rem_nxt = DW'(try_v - d1_v);
      q_nxt   = VW'(q_dbl + (DW+1)'(1));
    end else begin
      rem_nxt = try_v[DW-1:0];
      q_nxt   = q_dbl[VW-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      item_r <= in_data;
    end
    if (cmd.div_init) begin
      a_r   <= item_r.volume;
      q_r   <= '0;
      rem_r <= '0;
      d_r   <= {1'b0, ahead_r} + {1'b0, behind_r};
    end else if (cmd.div_step) begin
      a_r   <= {a_r[VW-2:0], 1'b0};
      q_r   <= q_nxt;
      rem_r <= rem_nxt;
    end
  end

  always_comb begin
    vol        = item_r.volume;
    ahead_nxt  = ahead_r;
    behind_nxt = behind_r;
    filled_nxt = filled_r;
    sum_nxt    = sum_r;
    spill_nxt  = '0;
    left_now   = (order_size_r > filled_r) ? (order_size_r - filled_r) : '0;
    past       = vol - ahead_r;
    sum_ext    = {1'b0, sum_r} + (SW+1)'(vol);
    add_ext    = {1'b0, behind_r} + {1'b0, vol};
    ca         = {1'b0, q_r} + DW'(rem_r != '0);
    cb         = vol - ca[VW-1:0];
    na         = $signed({2'b00, ahead_r}) - $signed({1'b0, ca});
    nb         = $signed({2'b00, behind_r}) - $signed({2'b00, cb});
    case (item_r.opcode)
      oqpt_pkg::OP_START: begin
        ahead_nxt  = init_ahead_r;
        behind_nxt = '0;
        filled_nxt = '0;
        sum_nxt    = '0;
      end
      oqpt_pkg::OP_TRADE: begin
        sum_nxt = sum_ext[SW] ? '1 : sum_ext[SW-1:0];
        if (vol > ahead_r) begin
          ahead_nxt = '0;
          if (left_now <= past) begin
            filled_nxt = order_size_r;
            spill_nxt  = past - left_now;
          end else begin
            filled_nxt = filled_r + past;
          end
        end else begin
          ahead_nxt = ahead_r - vol;
        end
      end
      oqpt_pkg::OP_CANCEL: begin
        if (behind_r == '0) begin
          ahead_nxt = (vol > ahead_r) ? '0 : (ahead_r - vol);
        end else begin
          if (na < 0) begin
            nb        = nb + na;
            ahead_nxt = '0;
          end else begin
            ahead_nxt = na[VW-1:0];
          end
          behind_nxt = (nb < 0) ? '0 : nb[VW-1:0];
        end
      end
      oqpt_pkg::OP_ADD: begin
        behind_nxt = add_ext[VW] ? '1 : add_ext[VW-1:0];
      end
      oqpt_pkg::OP_CLEAR: begin
        ahead_nxt  = '0;
        behind_nxt = '0;
      end
      default: ;
    endcase
    left_nxt = (order_size_r > filled_nxt) ? (order_size_r - filled_nxt) : '0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ahead_r  <= '0;
      behind_r <= '0;
      filled_r <= '0;
      sum_r    <= '0;
    end else if (cmd.commit) begin
      ahead_r  <= ahead_nxt;
      behind_r <= behind_nxt;
      filled_r <= filled_nxt;
      sum_r    <= sum_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.commit) begin
      out_r.spillover_volume <= spill_nxt;
      out_r.queue_ahead      <= ahead_nxt;
      out_r.queue_behind     <= behind_nxt;
      out_r.executed_volume  <= filled_nxt;
      out_r.unfilled_volume  <= left_nxt;
      out_r.fully_executed   <= (filled_nxt >= order_size_r);
      out_r.traded_total     <= sum_nxt;
    end
  end

endmodule

// ===== rtl/core/order_queue_position_tracker.sv =====
// Top level of the order queue position tracker.
// Usage:
//   Input channel in_valid/in_ready/in_data carries one event item: opcode
//   (start, trade, cancel, add behind, clear) and its volume. Output channel
//   out_valid/out_ready/out_data returns one result item per event: spillover,
//   queue ahead/behind, executed and remaining volume, full-fill flag and the
//   saturating traded total.
//   cfg_we/cfg_index/cfg_wdata write the order size and the initial queue
//   ahead; write them only while no item is in flight.
//   After acceptance an item passes a prepare state and then a finish state, where
//   its result is committed; a cancel with volume behind also runs the bit-serial
//   divider between them, one volume bit per cycle, on the ceiling of the proportional share.
//   One item is processed at a time; in_ready rises again once the result is in
//   the output register, so the next item is taken while it waits.
//   If out_ready stays low the finished item waits in the output register and
//   the following item holds in its last stage until that register frees.
//   Reset (rst_n low, synchronous) clears all counters, sets order size to 1
//   and initial queue ahead to 0, and empties the output register.
`timescale 1ns / 1ps

module order_queue_position_tracker (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 in_valid,
  output logic                                 in_ready,
  input  oqpt_pkg::in_t                        in_data,
  output logic                                 out_valid,
  input  logic                                 out_ready,
  output oqpt_pkg::out_t                       out_data,
  input  logic                                 cfg_we,
  input  logic [oqpt_pkg::CFG_IDX_BITS-1:0]    cfg_index,
  input  logic [oqpt_pkg::VOLUME_BITS-1:0]     cfg_wdata
);

  oqpt_pkg::cmd_t    cmd;
  oqpt_pkg::status_t status;

  oqpt_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .status    (status),
    .cmd       (cmd)
  );

  oqpt_dp u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .in_data   (in_data),
    .cmd       (cmd),
    .status    (status),
    .out_data  (out_data)
  );

endmodule
